// ----- src/lapedge_pkg.sv -----
// Shared types, sizes and constants of the Laplacian edge threshold core.
package lapedge_pkg;

    // Frame limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    // Counter and size widths derived from the frame limits
    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
    localparam int LAG_W = $clog2(MAX_WIDTH + 2);

    // Configuration register widths and reset values
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 13;
    localparam int THR_W      = 8;

    localparam logic [IMG_W_W-1:0] IMG_W_RST = 11'd1024;
    localparam logic [IMG_H_W-1:0] IMG_H_RST = 13'd1024;
    localparam logic [THR_W-1:0]   THR_RST   = 8'd128;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH    = 2'd0,
        CFG_IMAGE_HEIGHT   = 2'd1,
        CFG_EDGE_THRESHOLD = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } t_op;

    // Luma weights, Q0.16
    localparam logic [15:0] LUMA_R = 16'd19595;
    localparam logic [15:0] LUMA_G = 16'd38470;
    localparam logic [15:0] LUMA_B = 16'd7471;

    // Result queue, depth must be a power of two
    localparam int RES_DEPTH = 8;
    localparam int RES_AW    = $clog2(RES_DEPTH);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix;

    // One slot issued to the row stores
    typedef struct packed {
        logic             emit;
        logic [COL_W-1:0] addr;
        t_pix             pix;
        logic             col_first;
        logic             row_first;
        logic             col_last;
        logic             row_last;
    } t_slot;

    typedef struct packed {
        t_pix lap;
        logic frame_end;
    } t_lap;

    typedef struct packed {
        logic edge_mark;
        logic frame_end;
    } t_res;

endpackage

// ----- src/lapedge_ram.sv -----
// Generic single-clock RAM, one write port, one registered read port, read-first.
module lapedge_ram #(
    parameter int  WIDTH = 24,
    parameter int  DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/lapedge_ctrl.sv -----
// Position, lag and drain state; one row-store slot per pixel or pending drain.
module lapedge_ctrl
    import lapedge_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  t_op              i_op,
    input  t_pix             i_pix,
    input  logic [WID_W-1:0] i_width,
    input  logic [HGT_W-1:0] i_height,
    output logic             o_slot_valid,
    output t_slot            o_slot
);

    logic [COL_W-1:0] r_in_col, n_in_col, r_out_col, n_out_col;
    logic [ROW_W-1:0] r_in_row, n_in_row, r_out_row, n_out_row;
    logic [LAG_W-1:0] r_lag, n_lag, r_pending, n_pending;
    logic             r_draining, n_draining;

    logic             restart, drain_ok, is_slot, emit;
    logic [COL_W-1:0] in_col_b, out_col_b;
    logic [ROW_W-1:0] in_row_b, out_row_b;
    logic [LAG_W-1:0] lag_b, pend_b;
    logic             in_col_last, in_row_last, out_col_last, out_row_last;

    always_comb begin
        // a pixel during a drain drops what is pending and restarts the frame
        restart   = (i_op == OP_PIXEL) && r_draining;
        lag_b     = restart ? '0 : r_lag;
        pend_b    = restart ? '0 : r_pending;
        in_col_b  = restart ? '0 : r_in_col;
        in_row_b  = restart ? '0 : r_in_row;
        out_col_b = restart ? '0 : r_out_col;
        out_row_b = restart ? '0 : r_out_row;

        drain_ok = (r_pending != '0) &&
                   (r_draining || ((r_in_col == '0) && (r_in_row == '0)));
        is_slot  = (i_op == OP_PIXEL) || drain_ok;
        emit     = is_slot && (pend_b != '0) &&
                   (lag_b >= (LAG_W'(i_width) + LAG_W'(1)));

        in_col_last  = (WID_W'(in_col_b) + WID_W'(1)) >= i_width;
        in_row_last  = (HGT_W'(in_row_b) + HGT_W'(1)) >= i_height;
        out_col_last = (WID_W'(out_col_b) + WID_W'(1)) >= i_width;
        out_row_last = (HGT_W'(out_row_b) + HGT_W'(1)) >= i_height;

        o_slot_valid     = i_accept && is_slot;
        o_slot.emit      = emit;
        o_slot.addr      = in_col_b;
        o_slot.pix       = (i_op == OP_PIXEL) ? i_pix : '0;
        o_slot.col_first = (out_col_b == '0);
        o_slot.row_first = (out_row_b == '0);
        o_slot.col_last  = out_col_last;
        o_slot.row_last  = out_row_last;

        n_in_col   = r_in_col;
        n_in_row   = r_in_row;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        n_lag      = r_lag;
        n_pending  = r_pending;
        n_draining = r_draining;

        if (i_accept && is_slot) begin
            n_draining = (i_op == OP_DRAIN);
            n_out_col  = out_col_b;
            n_out_row  = out_row_b;
            if (emit) begin
                n_out_col = out_col_last ? '0 : out_col_b + COL_W'(1);
                if (out_col_last) begin
                    n_out_row = out_row_last ? '0 : out_row_b + ROW_W'(1);
                end
            end
            n_in_col = in_col_last ? '0 : in_col_b + COL_W'(1);
            n_in_row = in_row_b;
            if ((i_op == OP_PIXEL) && in_col_last) begin
                n_in_row = in_row_last ? '0 : in_row_b + ROW_W'(1);
            end
            n_lag = emit ? lag_b : lag_b + LAG_W'(1);
            if (i_op == OP_PIXEL) begin
                n_pending = emit ? pend_b : pend_b + LAG_W'(1);
            end else begin
                n_pending = emit ? pend_b - LAG_W'(1) : pend_b;
            end
            // last pending result gone: start the next frame clean
            if ((i_op == OP_DRAIN) && (n_pending == '0)) begin
                n_in_col   = '0;
                n_lag      = '0;
                n_draining = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_lag      <= '0;
            r_pending  <= '0;
            r_draining <= 1'b0;
        end else begin
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_lag      <= n_lag;
            r_pending  <= n_pending;
            r_draining <= n_draining;
        end
    end

    a_pending_within_lag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= r_lag)
        else $error("pending count above lag count");

    a_idle_is_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending == '0) |-> ((r_lag == '0) && !r_draining))
        else $error("no result pending but lag or drain state left over");

endmodule

// ----- src/lapedge_window.sv -----
// Row stores with read-modify-write, neighbour window and per-channel Laplacian.
module lapedge_window
    import lapedge_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_slot_valid,
    input  t_slot      i_slot,
    output logic       o_lap_valid,
    output t_lap       o_lap,
    output logic [1:0] o_inflight
);

    t_slot r_s1;
    logic  r_s1_valid, r_s1_fwd;
    t_pix  r_h_older1, r_h_newer1, r_h_newer2, r_h_pix1;
    t_lap  r_lap;
    logic  r_lap_valid;

    logic [$bits(t_pix)-1:0] older_q, newer_q;
    t_pix older_old, newer_old, ce, up, dn, lf, rt, lap;

    function automatic logic [7:0] lap_chan(input logic [7:0] c, input logic [7:0] u,
                                            input logic [7:0] d, input logic [7:0] l,
                                            input logic [7:0] r);
        logic signed [10:0] v;
        logic [7:0]         res;
        v = $signed({1'b0, c, 2'b00}) - $signed({3'b000, u}) - $signed({3'b000, d})
            - $signed({3'b000, l}) - $signed({3'b000, r});
        if (v < 0) begin
            res = 8'd0;
        end else if (v > 11'sd255) begin
            res = 8'd255;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

    // older store: takes the value pushed out of the newer store
    lapedge_ram #(.WIDTH($bits(t_pix)), .DEPTH(MAX_WIDTH)) u_older (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1.addr),
        .i_wdata (newer_old),
        .i_re    (i_slot_valid),
        .i_raddr (i_slot.addr),
        .o_rdata (older_q)
    );

    lapedge_ram #(.WIDTH($bits(t_pix)), .DEPTH(MAX_WIDTH)) u_newer (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1.addr),
        .i_wdata (r_s1.pix),
        .i_re    (i_slot_valid),
        .i_raddr (i_slot.addr),
        .o_rdata (newer_q)
    );

    always_comb begin
        // read overlapped the write of the previous slot to the same column
        older_old = r_s1_fwd ? r_h_newer1 : older_q;
        newer_old = r_s1_fwd ? r_h_pix1 : newer_q;

        ce = r_h_newer1;
        up = r_s1.row_first ? ce : r_h_older1;
        dn = r_s1.row_last ? ce : r_h_pix1;
        lf = r_s1.col_first ? ce : r_h_newer2;
        rt = r_s1.col_last ? ce : newer_old;

        lap.red   = lap_chan(ce.red, up.red, dn.red, lf.red, rt.red);
        lap.green = lap_chan(ce.green, up.green, dn.green, lf.green, rt.green);
        lap.blue  = lap_chan(ce.blue, up.blue, dn.blue, lf.blue, rt.blue);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_lap_valid <= 1'b0;
        end else begin
            r_s1_valid  <= i_slot_valid;
            r_lap_valid <= r_s1_valid && r_s1.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_slot_valid) begin
            r_s1     <= i_slot;
            r_s1_fwd <= r_s1_valid && (r_s1.addr == i_slot.addr);
        end
        if (r_s1_valid) begin
            r_h_older1 <= older_old;
            r_h_newer1 <= newer_old;
            r_h_newer2 <= r_h_newer1;
            r_h_pix1   <= r_s1.pix;
        end
        if (r_s1_valid && r_s1.emit) begin
            r_lap.lap       <= lap;
            r_lap.frame_end <= r_s1.col_last && r_s1.row_last;
        end
    end

    assign o_lap_valid = r_lap_valid;
    assign o_lap       = r_lap;
    assign o_inflight  = 2'(r_s1_valid && r_s1.emit) + 2'(r_lap_valid);

endmodule

// ----- src/lapedge_result.sv -----
// Luma weighting, threshold compare and result queue toward the output stream.
module lapedge_result
    import lapedge_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_lap_valid,
    input  t_lap              i_lap,
    input  logic [THR_W-1:0]  i_thresh,
    output logic              o_res_valid,
    output t_res              o_res,
    input  logic              i_res_ready,
    output logic [RES_AW:0]   o_level
);

    logic [7:0]        r_luma;
    logic              r_luma_valid, r_luma_end;
    t_res              r_fifo [RES_DEPTH];
    logic [RES_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [RES_AW:0]   r_count, n_count;
    logic [25:0]       luma_sum;
    logic              wr, rd;

    assign luma_sum = 26'(LUMA_R) * 26'(i_lap.lap.red)
                    + 26'(LUMA_G) * 26'(i_lap.lap.green)
                    + 26'(LUMA_B) * 26'(i_lap.lap.blue);

    assign wr          = r_luma_valid;
    assign o_res_valid = (r_count != '0);
    assign rd          = o_res_valid && i_res_ready;
    assign o_res       = r_fifo[r_rd_ptr];
    assign o_level     = r_count + (RES_AW + 1)'(r_luma_valid);

    always_comb begin
        n_count = r_count;
        if (wr && !rd) begin
            n_count = r_count + (RES_AW + 1)'(1);
        end else if (!wr && rd) begin
            n_count = r_count - (RES_AW + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_luma_valid <= 1'b0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_count      <= '0;
        end else begin
            r_luma_valid <= i_lap_valid;
            r_count      <= n_count;
            if (wr) begin
                r_wr_ptr <= r_wr_ptr + RES_AW'(1);
            end
            if (rd) begin
                r_rd_ptr <= r_rd_ptr + RES_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_lap_valid) begin
            r_luma     <= luma_sum[23:16];
            r_luma_end <= i_lap.frame_end;
        end
        if (wr) begin
            r_fifo[r_wr_ptr].edge_mark <= (r_luma > i_thresh);
            r_fifo[r_wr_ptr].frame_end <= r_luma_end;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr |-> (r_count < (RES_AW + 1)'(RES_DEPTH)))
        else $error("result queue written while full");

endmodule

// ----- src/laplacian_edge_threshold_core.sv -----
// Top level: streaming Laplacian edge detector with luma threshold.
// Throughput: one word per cycle, sustained, as long as the output side keeps taking results.
// Result path: a pixel's result is released by the word that arrives W+1 slots later; that word
//   passes the slot, Laplacian, luma and queue registers before it shows on the master side.
// Reset: counters, drain state and result queue clear at once; the two row stores are not
//   cleared and configuration returns to width 1024, height 1024, threshold 128.
module laplacian_edge_threshold_core
    import lapedge_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // slave side
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [23:0]           i_s_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
    input  logic                  i_s_tuser,   // operation: 0 pixel, 1 drain
    // master side
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [7:0]            o_m_tdata,   // edge_mark[0], zeros above
    output logic                  o_m_tlast    // frame_end
);

    localparam int CRD_W = RES_AW + 2;

    logic [IMG_W_W-1:0] r_cfg_width;
    logic [IMG_H_W-1:0] r_cfg_height;
    logic [THR_W-1:0]   r_cfg_thresh;

    logic [WID_W-1:0]  eff_w;
    logic [HGT_W-1:0]  eff_h;
    logic              accept;
    t_op               op;
    t_pix              pix;
    logic              slot_valid;
    t_slot             slot;
    logic              lap_valid;
    t_lap              lap;
    logic [1:0]        win_inflight;
    logic [RES_AW:0]   res_level;
    logic [CRD_W-1:0]  credit_use;
    t_res              res;

    // Configuration registers; the user must write them only between frames; the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= IMG_W_RST;
            r_cfg_height <= IMG_H_RST;
            r_cfg_thresh <= THR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:    r_cfg_width  <= i_cfg_wdata[IMG_W_W-1:0];
                CFG_IMAGE_HEIGHT:   r_cfg_height <= i_cfg_wdata[IMG_H_W-1:0];
                CFG_EDGE_THRESHOLD: r_cfg_thresh <= i_cfg_wdata[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Effective frame size: zero counts as one, saturate at MAX_WIDTH and MAX_HEIGHT
    always_comb begin
        if (r_cfg_width == '0) begin
            eff_w = WID_W'(1);
        end else if (32'(r_cfg_width) > MAX_WIDTH) begin
            eff_w = WID_W'(MAX_WIDTH);
        end else begin
            eff_w = WID_W'(r_cfg_width);
        end
        if (r_cfg_height == '0) begin
            eff_h = HGT_W'(1);
        end else if (32'(r_cfg_height) > MAX_HEIGHT) begin
            eff_h = HGT_W'(MAX_HEIGHT);
        end else begin
            eff_h = HGT_W'(r_cfg_height);
        end
    end

    // Hold off input only when every queue entry is spoken for by a result in
    // the queue or one still travelling down the pipe
    assign credit_use = CRD_W'(win_inflight) + CRD_W'(res_level);
    assign o_s_tready = (credit_use < CRD_W'(RES_DEPTH));
    assign accept     = i_s_tvalid && o_s_tready;

    assign op        = t_op'(i_s_tuser);
    assign pix.red   = i_s_tdata[7:0];
    assign pix.green = i_s_tdata[15:8];
    assign pix.blue  = i_s_tdata[23:16];

    // Positions, lag and drain handling; one store slot per accepted pixel or pending drain word
    lapedge_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_op         (op),
        .i_pix        (pix),
        .i_width      (eff_w),
        .i_height     (eff_h),
        .o_slot_valid (slot_valid),
        .o_slot       (slot)
    );

    // Row stores, neighbour window and Laplacian per channel
    lapedge_window u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_slot_valid (slot_valid),
        .i_slot       (slot),
        .o_lap_valid  (lap_valid),
        .o_lap        (lap),
        .o_inflight   (win_inflight)
    );

    // Luma, threshold and the output queue
    lapedge_result u_result (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lap_valid (lap_valid),
        .i_lap       (lap),
        .i_thresh    (r_cfg_thresh),
        .o_res_valid (o_m_tvalid),
        .o_res       (res),
        .i_res_ready (i_m_tready),
        .o_level     (res_level)
    );

    assign o_m_tdata = {7'b0000000, res.edge_mark};
    assign o_m_tlast = res.frame_end;

endmodule
